// File: sv/multichannel_mean_variance_minmax_unit_macros.svh
// Assertion macros for the mean/variance/min/max unit checker.
// No dependencies.
`ifndef MULTICHANNEL_MEAN_VARIANCE_MINMAX_UNIT_MACROS_SVH
`define MULTICHANNEL_MEAN_VARIANCE_MINMAX_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define MMV_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define MMV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: sv/mmv_pkg.sv
// Package for the mean/variance/min/max unit: widths, payload types and control structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mmv_pkg;
  localparam int MaxItems     = 65535;
  localparam int ValueWidth   = 24;
  localparam int FractionBits = 8;
  localparam int NumChannels  = 6;
  localparam int ChanW        = 3;
  localparam int CountW       = 16;
  localparam int SumW         = 40;
  localparam int SqW          = 64;
  localparam int NumW         = SqW + CountW + FractionBits;  // numerator of variance
  localparam int DenW         = 2 * CountW;
  localparam int DivSteps     = NumW;
  localparam int StepW        = 7;

  typedef struct packed {
    logic [23:0] inter_arrival;
    logic [23:0] service_time;
    logic [23:0] arrival_time;
    logic [23:0] begin_service;
    logic [23:0] end_service;
    logic [23:0] queue_length;
    logic        final_record;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  channel;
    logic [31:0] mean_value;
    logic [55:0] variance_value;
    logic [23:0] minimum;
    logic [23:0] maximum;
    logic [15:0] record_count;
    logic        dropped_flag;
    logic        last_of_run;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_LOAD, OP_MUL_A, OP_MUL_B, OP_DIV_INIT, OP_DIV_STEP, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    logic              accum;     // accumulate the input item
    logic              clear;     // return statistics to reset
    dp_op_t            op;
    logic [ChanW-1:0]  chan;
    logic              var_div;   // 1 = variance division, 0 = mean division
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_stat_t;
endpackage
`default_nettype wire

// File: sv/mmv_datapath.sv
// Datapath: six accumulate/min/max lanes, a shared 32x32 multiplier and a
// restoring divider, one quotient bit per cycle. Uses mmv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mmv_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mmv_pkg::in_item_t in_item,
  input  wire mmv_pkg::dp_cmd_t  cmd,
  output mmv_pkg::dp_stat_t      stat,
  output mmv_pkg::out_item_t     out_item
);
  localparam int VW = mmv_pkg::ValueWidth;
  localparam int NC = mmv_pkg::NumChannels;

  logic [mmv_pkg::SumW-1:0]   sum_r [NC];
  logic [mmv_pkg::SqW-1:0]    sq_r  [NC];
  logic [VW-1:0]              min_r [NC];
  logic [VW-1:0]              max_r [NC];
  logic [mmv_pkg::CountW-1:0] count_r;
  logic                       dropped_r;

  logic [VW-1:0] v [NC];
  always_comb begin
    v[0] = in_item.inter_arrival[VW-1:0];
    v[1] = in_item.service_time[VW-1:0];
    v[2] = in_item.arrival_time[VW-1:0];
    v[3] = in_item.begin_service[VW-1:0];
    v[4] = in_item.end_service[VW-1:0];
    v[5] = in_item.queue_length[VW-1:0];
  end

  wire logic room = ({16'd0, count_r} < 32'(mmv_pkg::MaxItems));

  // Lane per channel; squares come from one 24x24 multiplier each.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      count_r   <= '0;
      dropped_r <= 1'b0;
      for (int c = 0; c < NC; c++) begin
        sum_r[c] <= '0;
        sq_r[c]  <= '0;
        min_r[c] <= '1;
        max_r[c] <= '0;
      end
    end else if (cmd.accum) begin
      if (room) begin
        count_r <= count_r + 16'd1;
        for (int c = 0; c < NC; c++) begin
          sum_r[c] <= sum_r[c] + mmv_pkg::SumW'(v[c]);
          sq_r[c]  <= sq_r[c] + mmv_pkg::SqW'(v[c]) * mmv_pkg::SqW'(v[c]);
          if (v[c] < min_r[c]) min_r[c] <= v[c];
          if (v[c] > max_r[c]) max_r[c] <= v[c];
        end
      end else begin
        dropped_r <= 1'b1;
      end
    end
  end

  // Report path: n*sq - sum^2 via partial products, then long division.
  logic [mmv_pkg::SumW-1:0]  s_sel;
  logic [mmv_pkg::SqW-1:0]   q_sel;
  logic [mmv_pkg::SumW-1:0]  s_r;
  logic [mmv_pkg::SqW-1:0]   q_r;
  logic [mmv_pkg::NumW-1:0]  nq_r;    // n * sumsq
  logic [2*mmv_pkg::SumW-1:0] ss_r;   // sum^2
  logic [mmv_pkg::NumW-1:0]  num_r;
  logic [mmv_pkg::DenW-1:0]  den_r;
  logic [mmv_pkg::DenW:0]    rem_r;
  logic [mmv_pkg::NumW-1:0]  quo_r;
  logic [mmv_pkg::StepW-1:0] step_r;
  logic [31:0]               mean_r;
  logic [31:0]               mul_a, mul_b;
  logic [63:0]               prod;
  logic [mmv_pkg::DenW:0]    trial;

  assign s_sel = sum_r[cmd.chan];
  assign q_sel = sq_r[cmd.chan];
  assign prod  = 64'(mul_a) * 64'(mul_b);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      mmv_pkg::OP_MUL_A: begin
        mul_a = 32'(count_r);
        mul_b = q_r[31:0];
      end
      mmv_pkg::OP_MUL_B: begin
        mul_a = 32'(count_r);
        mul_b = q_r[63:32];
      end
      default: begin
        mul_a = 32'(count_r);
        mul_b = 32'(count_r);
      end
    endcase
  end

  // sum^2 with sum <= 40 bits: split into 20-bit halves over the load cycle.
  logic [19:0] sh, sl;
  assign sh = s_sel[39:20];
  assign sl = s_sel[19:0];

  assign trial = {rem_r[mmv_pkg::DenW-1:0], num_r[mmv_pkg::NumW-1]} - {1'b0, den_r};

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      mmv_pkg::OP_LOAD: begin
        s_r  <= s_sel;
        q_r  <= q_sel;
        ss_r <= ({40'd0, 40'(sh) * 40'(sh)} << 40)
                + ({39'd0, 40'(sh) * 40'(sl), 1'b0} << 20)
                + {40'd0, 40'(sl) * 40'(sl)};
        nq_r <= '0;
      end
      mmv_pkg::OP_MUL_A: nq_r <= mmv_pkg::NumW'(prod);
      mmv_pkg::OP_MUL_B: nq_r <= nq_r + (mmv_pkg::NumW'(prod) << 32);
      mmv_pkg::OP_DIV_INIT: begin
        rem_r  <= '0;
        quo_r  <= '0;
        step_r <= '0;
        den_r  <= cmd.var_div ? prod[mmv_pkg::DenW-1:0] : 32'(count_r);
        if (cmd.var_div) begin
          num_r <= (nq_r < mmv_pkg::NumW'(ss_r)) ? '0
                 : (nq_r - mmv_pkg::NumW'(ss_r)) << mmv_pkg::FractionBits;
        end else begin
          num_r <= mmv_pkg::NumW'(s_r) << mmv_pkg::FractionBits;
        end
      end
      mmv_pkg::OP_DIV_STEP: begin
        step_r <= step_r + 1'b1;
        num_r  <= num_r << 1;
        if (!trial[mmv_pkg::DenW]) begin
          rem_r <= trial;
          quo_r <= {quo_r[mmv_pkg::NumW-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[mmv_pkg::DenW-1:0], num_r[mmv_pkg::NumW-1]};
          quo_r <= {quo_r[mmv_pkg::NumW-2:0], 1'b0};
        end
        if (step_r == mmv_pkg::StepW'(mmv_pkg::DivSteps - 1) && !cmd.var_div)
          mean_r <= (count_r == '0) ? '0 : 32'({quo_r[mmv_pkg::NumW-2:0], !trial[mmv_pkg::DenW]});
      end
      default: ;
    endcase
  end

  assign stat.div_done = (step_r == mmv_pkg::StepW'(mmv_pkg::DivSteps));

  always_ff @(posedge clk) begin
    if (cmd.op == mmv_pkg::OP_EMIT) begin
      out_item.channel        <= cmd.chan;
      out_item.mean_value     <= mean_r;
      out_item.variance_value <= (count_r == '0) ? '0 : quo_r[55:0];
      out_item.minimum        <= 24'(min_r[cmd.chan]);
      out_item.maximum        <= 24'(max_r[cmd.chan]);
      out_item.record_count   <= count_r;
      out_item.dropped_flag   <= dropped_r;
      out_item.last_of_run    <= (cmd.chan == mmv_pkg::ChanW'(NC - 1));
    end
  end
endmodule
`default_nettype wire

// File: sv/mmv_control.sv
// Controller: takes items, sequences the report over six channels.
// Uses mmv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mmv_control (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              final_record,
  input  wire mmv_pkg::dp_stat_t stat,
  output logic                   busy,
  output mmv_pkg::dp_cmd_t       cmd,
  output logic                   out_valid
);
  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_MUL_A, S_MUL_B, S_MDIV_INIT, S_MDIV, S_VDIV_INIT, S_VDIV,
    S_EMIT, S_CLEAR
  } state_t;

  state_t                   state_r, state_nxt;
  logic [mmv_pkg::ChanW-1:0] chan_r, chan_nxt;
  logic                     out_valid_nxt;

  wire logic take = start && !busy;

  always_comb begin
    state_nxt     = state_r;
    chan_nxt      = chan_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    cmd.chan      = chan_r;
    cmd.accum     = take;
    unique case (state_r)
      S_IDLE: if (take && final_record) begin
        state_nxt = S_LOAD;
        chan_nxt  = '0;
      end
      S_LOAD: begin
        cmd.op    = mmv_pkg::OP_LOAD;
        state_nxt = S_MUL_A;
      end
      S_MUL_A: begin
        cmd.op    = mmv_pkg::OP_MUL_A;
        state_nxt = S_MUL_B;
      end
      S_MUL_B: begin
        cmd.op    = mmv_pkg::OP_MUL_B;
        state_nxt = S_MDIV_INIT;
      end
      S_MDIV_INIT: begin
        cmd.op    = mmv_pkg::OP_DIV_INIT;
        state_nxt = S_MDIV;
      end
      S_MDIV: begin
        cmd.op = stat.div_done ? mmv_pkg::OP_NONE : mmv_pkg::OP_DIV_STEP;
        if (stat.div_done) state_nxt = S_VDIV_INIT;
      end
      S_VDIV_INIT: begin
        cmd.op      = mmv_pkg::OP_DIV_INIT;
        cmd.var_div = 1'b1;
        state_nxt   = S_VDIV;
      end
      S_VDIV: begin
        cmd.var_div = 1'b1;
        cmd.op      = stat.div_done ? mmv_pkg::OP_EMIT : mmv_pkg::OP_DIV_STEP;
        if (stat.div_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        out_valid_nxt = 1'b0;
        if (chan_r == mmv_pkg::ChanW'(mmv_pkg::NumChannels - 1)) begin
          state_nxt = S_CLEAR;
        end else begin
          chan_nxt  = chan_r + 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_CLEAR: begin
        cmd.clear = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_VDIV && stat.div_done) out_valid_nxt = 1'b1;
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      chan_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      chan_r    <= chan_nxt;
      out_valid <= out_valid_nxt;
    end
  end
endmodule
`default_nettype wire

// File: sv/multichannel_mean_variance_minmax_unit.sv
// Top level of the six-channel mean/variance/min/max unit.
// Uses mmv_pkg, mmv_control and mmv_datapath.
`timescale 1ns / 1ps
`default_nettype none
// A record is taken in any cycle with start high and busy low; a non-final
// record leaves busy low, so records may arrive every cycle. A final record
// starts a report: for each channel the load and multiply steps (S_LOAD,
// S_MUL_A, S_MUL_B), two restoring divisions on a shared divider (each an init
// step, 88 steps of one quotient bit and a finishing step) and an emit step;
// busy stays high through a closing clear step. Each result shows for one cycle
// with out_valid; the receiver cannot stall it.
module multichannel_mean_variance_minmax_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire mmv_pkg::in_item_t  in_item,
  output logic                    out_valid,
  output mmv_pkg::out_item_t      out_item
);
  mmv_pkg::dp_cmd_t  cmd;
  mmv_pkg::dp_stat_t stat;

  mmv_control u_control (
    .clk, .rst_n, .start, .final_record(in_item.final_record), .stat,
    .busy, .cmd, .out_valid
  );

  mmv_datapath u_datapath (
    .clk, .rst_n, .in_item, .cmd, .stat, .out_item
  );
endmodule
`default_nettype wire

// File: sv/mmv_checker.sv
// Port-level checker for the mean/variance/min/max unit, bound to the top.
// Uses the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "multichannel_mean_variance_minmax_unit_macros.svh"
module mmv_port_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire mmv_pkg::in_item_t  in_item,
  input wire logic               out_valid,
  input wire mmv_pkg::out_item_t out_item
);
  `MMV_ASSERT_NEXT(a_final_busy, clk, rst_n, start && !busy && in_item.final_record, busy, "final item did not start report")
  `MMV_ASSERT_IMPL(a_out_in_report, clk, rst_n, out_valid, busy || out_item.last_of_run, "result outside report")
  `MMV_ASSERT_IMPL(a_chan_range, clk, rst_n, out_valid, out_item.channel <= 3'd5, "bad channel")
  `MMV_ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid, !out_valid, "result strobe held")
endmodule
bind multichannel_mean_variance_minmax_unit mmv_port_checker u_checker (.*);
`default_nettype wire

// File: sim/mmv_checker.sv
// Checker for the six-channel mean/variance/min/max unit: follows accepted records,
// predicts each report and compares the result items field by field.
// Depends on mmv_pkg.
`timescale 1ns / 1ps
module mmv_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  mmv_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  mmv_pkg::out_item_t out_item,
  output int                 fail_count,
  output int                 pending,
  output int                 reports
);
  import mmv_pkg::*;

  logic [15:0] rec_count;
  logic [39:0] sum_acc [NumChannels];
  logic [63:0] sq_acc [NumChannels];
  logic [23:0] min_acc [NumChannels];
  logic [23:0] max_acc [NumChannels];
  logic        drop_seen;
  out_item_t   report_q[$];

  assign pending = report_q.size();

  task automatic clear_stats();
    rec_count = '0;
    drop_seen = 1'b0;
    for (int c = 0; c < NumChannels; c++) begin
      sum_acc[c] = '0;
      sq_acc[c]  = '0;
      min_acc[c] = '1;
      max_acc[c] = '0;
    end
  endtask

  function automatic logic [55:0] pop_variance(logic [15:0] n, logic [39:0] s,
                                               logic [63:0] sq);
    logic [95:0] lhs;
    logic [95:0] rhs;
    logic [95:0] den;
    if (n == 0) return '0;
    lhs = 96'(n) * 96'(sq);
    rhs = 96'(s) * 96'(s);
    if (lhs < rhs) return '0;
    den = 96'(n) * 96'(n);
    return 56'(((lhs - rhs) << FractionBits) / den);
  endfunction

  task automatic take_record(in_item_t r);
    logic [23:0] v [NumChannels];
    out_item_t   res;
    v = '{r.inter_arrival, r.service_time, r.arrival_time,
          r.begin_service, r.end_service, r.queue_length};
    if (rec_count < MaxItems) begin
      for (int c = 0; c < NumChannels; c++) begin
        sum_acc[c] += 40'(v[c]);
        sq_acc[c]  += 64'(v[c]) * 64'(v[c]);
        if (v[c] < min_acc[c]) min_acc[c] = v[c];
        if (v[c] > max_acc[c]) max_acc[c] = v[c];
      end
      rec_count++;
    end else begin
      drop_seen = 1'b1;
    end
    if (!r.final_record) return;
    for (int c = 0; c < NumChannels; c++) begin
      res.channel        = 3'(c);
      res.mean_value     = (rec_count == 0) ? '0 :
                           32'((48'(sum_acc[c]) << FractionBits) / 48'(rec_count));
      res.variance_value = pop_variance(rec_count, sum_acc[c], sq_acc[c]);
      res.minimum        = min_acc[c];
      res.maximum        = max_acc[c];
      res.record_count   = rec_count;
      res.dropped_flag   = drop_seen;
      res.last_of_run    = (c == NumChannels - 1);
      report_q.push_back(res);
    end
    reports++;
    clear_stats();
  endtask

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    reports    = 0;
    clear_stats();
  end

  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst_n) begin
      clear_stats();
      report_q.delete();
    end else begin
      if (out_valid) begin
        if (report_q.size() == 0) begin
          $error("result item with nothing expected: channel %0d", out_item.channel);
          fail_count++;
        end else begin
          exp_r = report_q.pop_front();
          check_field("channel", exp_r.channel, out_item.channel);
          check_field("mean_value", exp_r.mean_value, out_item.mean_value);
          check_field("variance_value", exp_r.variance_value, out_item.variance_value);
          check_field("minimum", exp_r.minimum, out_item.minimum);
          check_field("maximum", exp_r.maximum, out_item.maximum);
          check_field("record_count", exp_r.record_count, out_item.record_count);
          check_field("dropped_flag", exp_r.dropped_flag, out_item.dropped_flag);
          check_field("last_of_run", exp_r.last_of_run, out_item.last_of_run);
        end
      end
      if (start && !busy) take_record(in_item);
    end
  end
endmodule

// File: sim/tb.sv
// Testbench top for the six-channel mean/variance/min/max unit: clock, reset,
// record stimulus, watchdog and verdict. Depends on mmv_pkg and mmv_checker.
`timescale 1ns / 1ps
module tb;
  import mmv_pkg::*;

  localparam int IdleLimit = 6000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;
  int        fail_count;
  int        pending;
  int        reports;
  int        idle_cycles;
  int        rec_sent;

  multichannel_mean_variance_minmax_unit dut (
    .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_item
  );

  mmv_checker chk (
    .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_item,
    .fail_count, .pending, .reports
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stop the run if neither side moves an item for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("timeout: no item moved for %0d cycles", IdleLimit);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [23:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return 24'($urandom_range(0, 255));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_record(logic fin);
    in_item_t r;
    r.inter_arrival = pick_sample();
    r.service_time  = pick_sample();
    r.arrival_time  = pick_sample();
    r.begin_service = pick_sample();
    r.end_service   = pick_sample();
    r.queue_length  = pick_sample();
    r.final_record  = fin;
    return r;
  endfunction

  function automatic in_item_t flat_record(logic [23:0] v, logic fin);
    return '{v, v, v, v, v, v, fin};
  endfunction

  // Hold start high until the record is taken; optionally idle afterwards.
  task automatic send(in_item_t r, int gap);
    start   <= 1'b1;
    in_item <= r;
    do @(posedge clk); while (busy);
    rec_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll < 10) return 0;
    if (roll < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  initial begin
    int len;
    int batches;
    start       = 1'b0;
    in_item     = '0;
    rst_n       = 1'b0;
    idle_cycles = 0;
    rec_sent    = 0;
    batches     = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-record batches at both extremes.
    send(flat_record('0, 1'b1), 0);
    send(flat_record('1, 1'b1), 2);
    // Extremes mixed in one batch, then distinct channels.
    send(flat_record('0, 1'b0), 0);
    send(flat_record('1, 1'b0), 1);
    send(flat_record('1, 1'b1), 0);
    send('{24'h000001, 24'h800000, 24'h00FF00, 24'h123456, 24'hFFFFFE, 24'h000003, 1'b0}, 0);
    send('{24'h000002, 24'h7FFFFF, 24'h0000FF, 24'h654321, 24'h000001, 24'h000005, 1'b0}, 3);
    send('{24'h000004, 24'h000000, 24'hFF0000, 24'hABCDEF, 24'h555555, 24'h000007, 1'b1}, 0);
    for (int i = 0; i < 5; i++) send(random_record(i == 4), pick_gap());

    while (rec_sent < 200) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) send(random_record(i == len - 1), pick_gap());
      batches++;
    end
    start <= 1'b0;

    wait (pending == 0);
    repeat (1200) @(posedge clk);
    $display("records sent: %0d in %0d random batches after the directed ones",
             rec_sent, batches);
    $display("reports checked: %0d, short and long batches with edge values", reports);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
